/* rtl/mtg_pkg.sv */
// mtg_pkg: shared constants, types and word functions of the mt19937-64 generator
// used by mt19937_64_generator; depends on nothing else
package mtg_pkg;

  localparam int WORD_W       = 64;
  localparam int STATE_WORDS  = 312;
  localparam int TWIST_OFFSET = 156;
  localparam int UNSEEDED     = STATE_WORDS + 1;
  localparam int ADDR_W       = $clog2(STATE_WORDS);
  localparam int IDX_W        = $clog2(UNSEEDED + 1);
  localparam int HALF_W       = WORD_W / 2;

  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_SEED = 1'b1;

  localparam logic [WORD_W-1:0] SEED_MULT    = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0] SEED_DEFAULT = 64'd5489;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [WORD_W-1:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WORD_W-1:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

  localparam int SEED_SHIFT = 62;
  localparam int TEMPER_U   = 29;
  localparam int TEMPER_S   = 17;
  localparam int TEMPER_T   = 37;
  localparam int TEMPER_L   = 43;

  // multiply phases of one seed word
  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_ACC  = 2'd1;
  localparam logic [1:0] PH_MID  = 2'd2;
  localparam logic [1:0] PH_LAST = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_FETCH,
    ST_TWIST
  } mtg_state_t;

  function automatic logic [WORD_W-1:0] mtg_twist(input logic [WORD_W-1:0] y,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] v;
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] mtg_temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] x;
    x = w;
    x = x ^ ((x >> TEMPER_U) & TEMPER_MASK_A);
    x = x ^ ((x << TEMPER_S) & TEMPER_MASK_B);
    x = x ^ ((x << TEMPER_T) & TEMPER_MASK_C);
    x = x ^ (x >> TEMPER_L);
    return x;
  endfunction

endpackage

/* rtl/mtg_ram.sv */
// mtg_ram: generic synchronous ram, one write port and two registered read ports
// standalone, no package use
module mtg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/mt19937_64_generator.sv */
// mt19937_64_generator: 64-bit mersenne twister with seeding and one twist per draw
// depends on mtg_pkg and mtg_ram
//
//   channel | handshake            | fields           | item
//   in      | in_valid, in_stall   | mode, seed_value | draw (mode 0) or seed (mode 1)
//   out     | out_valid, out_stall | random_word      | one tempered word per draw
//
// a draw is accepted in idle, reads the current and next word, then the far word, and in
// the twist state writes the twisted word back and loads its tempered form into the output
// register; the next item is taken once back in idle; a seed writes word 0 on acceptance,
// then runs each remaining word through the low, acc, mid and last phases of one shared
// 32x32 multiplier; a draw before any seed runs the 5489 seed first
// reset clears control only; a stalled output holds the next draw in its twist cycle
module mt19937_64_generator #(
  parameter int STATE_WORDS  = mtg_pkg::STATE_WORDS,
  parameter int TWIST_OFFSET = mtg_pkg::TWIST_OFFSET
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [mtg_pkg::WORD_W-1:0]   seed_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mtg_pkg::WORD_W-1:0]   random_word
);

  localparam int AW       = $clog2(STATE_WORDS);
  localparam int IW       = $clog2(STATE_WORDS + 2);
  localparam int HW       = mtg_pkg::HALF_W;
  localparam int WW       = mtg_pkg::WORD_W;
  localparam int UNSEEDED = STATE_WORDS + 1;

  mtg_pkg::mtg_state_t state, state_next;

  logic [IW-1:0] idx;
  logic          draw_pending;
  logic [1:0]    phase;
  logic [AW-1:0] seed_k;
  logic [WW-1:0] prev;
  logic [WW-1:0] acc;
  logic [WW-1:0] prod;
  logic [WW-1:0] y_word;

  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [WW-1:0] rdata_a;
  logic [WW-1:0] rdata_b;

  logic [AW-1:0] cur_addr;
  logic [AW-1:0] next_addr;
  logic [AW-1:0] far_addr;
  logic [WW-1:0] seed_x;
  logic [HW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic [WW-1:0] mul_p;
  logic [WW-1:0] seed_word;
  logic [WW-1:0] twisted;
  logic          out_free;
  logic          in_fire;
  logic          seed_last;

  mtg_ram #(
    .WIDTH(mtg_pkg::WORD_W),
    .DEPTH(STATE_WORDS)
  ) u_table (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  assign cur_addr  = idx[AW-1:0];
  assign next_addr = (cur_addr == AW'(STATE_WORDS - 1)) ? '0 : cur_addr + 1'b1;
  assign far_addr  = (cur_addr >= AW'(TWIST_OFFSET))
                   ? cur_addr - AW'(TWIST_OFFSET)
                   : cur_addr + AW'(TWIST_OFFSET);

  // seed recurrence, low 64 bits of the product from three 32x32 partial products
  assign seed_x = prev ^ (prev >> mtg_pkg::SEED_SHIFT);

  always_comb begin
    case (phase)
      mtg_pkg::PH_LOW: begin
        mul_a = seed_x[HW-1:0];
        mul_b = mtg_pkg::SEED_MULT[HW-1:0];
      end
      mtg_pkg::PH_ACC: begin
        mul_a = seed_x[WW-1:HW];
        mul_b = mtg_pkg::SEED_MULT[HW-1:0];
      end
      default: begin
        mul_a = seed_x[HW-1:0];
        mul_b = mtg_pkg::SEED_MULT[WW-1:HW];
      end
    endcase
  end

  assign mul_p     = WW'(mul_a) * WW'(mul_b);
  assign seed_word = acc + {prod[HW-1:0], {HW{1'b0}}};
  assign seed_last = (seed_k == AW'(STATE_WORDS - 1));
  assign twisted   = mtg_pkg::mtg_twist(y_word, rdata_a);
  assign out_free  = !out_valid || !out_stall;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    we         = 1'b0;
    waddr      = cur_addr;
    wdata      = twisted;
    raddr_a    = cur_addr;
    raddr_b    = next_addr;
    unique case (state)
      mtg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (mode == mtg_pkg::MODE_SEED) begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = seed_value;
            state_next = mtg_pkg::ST_SEED;
          end else if (idx == IW'(UNSEEDED)) begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = mtg_pkg::SEED_DEFAULT;
            state_next = mtg_pkg::ST_SEED;
          end else begin
            state_next = mtg_pkg::ST_READ;
          end
        end
      end
      mtg_pkg::ST_SEED: begin
        if (phase == mtg_pkg::PH_LAST) begin
          we    = 1'b1;
          waddr = seed_k;
          wdata = seed_word;
          if (seed_last) begin
            state_next = draw_pending ? mtg_pkg::ST_READ : mtg_pkg::ST_IDLE;
          end
        end
      end
      mtg_pkg::ST_READ: begin
        state_next = mtg_pkg::ST_FETCH;
      end
      mtg_pkg::ST_FETCH: begin
        raddr_a    = far_addr;
        state_next = mtg_pkg::ST_TWIST;
      end
      mtg_pkg::ST_TWIST: begin
        raddr_a = far_addr;
        if (out_free) begin
          we         = 1'b1;
          state_next = mtg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtg_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= IW'(UNSEEDED);
      draw_pending <= 1'b0;
      phase        <= mtg_pkg::PH_LOW;
      out_valid    <= 1'b0;
    end else begin
      if (state == mtg_pkg::ST_TWIST && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        mtg_pkg::ST_IDLE: begin
          phase <= mtg_pkg::PH_LOW;
          if (in_fire) begin
            if (mode == mtg_pkg::MODE_SEED) begin
              draw_pending <= 1'b0;
            end else if (idx == IW'(UNSEEDED)) begin
              draw_pending <= 1'b1;
            end else if (idx >= IW'(STATE_WORDS)) begin
              idx <= '0;
            end
          end
        end
        mtg_pkg::ST_SEED: begin
          phase <= phase + 1'b1;
          if (phase == mtg_pkg::PH_LAST && seed_last) begin
            idx          <= draw_pending ? '0 : IW'(STATE_WORDS);
            draw_pending <= 1'b0;
          end
        end
        mtg_pkg::ST_TWIST: begin
          if (out_free) begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mtg_pkg::ST_IDLE: begin
        seed_k <= AW'(1);
        prev   <= (mode == mtg_pkg::MODE_SEED) ? seed_value : mtg_pkg::SEED_DEFAULT;
      end
      mtg_pkg::ST_SEED: begin
        prod <= mul_p;
        case (phase)
          mtg_pkg::PH_ACC: begin
            acc <= prod + WW'(seed_k);
          end
          mtg_pkg::PH_MID: begin
            acc <= acc + {prod[HW-1:0], {HW{1'b0}}};
          end
          mtg_pkg::PH_LAST: begin
            prev   <= seed_word;
            seed_k <= seed_k + 1'b1;
          end
          default: begin
          end
        endcase
      end
      mtg_pkg::ST_FETCH: begin
        y_word <= {rdata_a[WW-1:HW-1], rdata_b[HW-2:0]};
      end
      mtg_pkg::ST_TWIST: begin
        if (out_free) begin
          random_word <= mtg_pkg::mtg_temper(twisted);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
